// ===== sv/length_prefixed_frame_echo_top_assert.svh =====
`ifndef LENGTH_PREFIXED_FRAME_ECHO_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_ECHO_TOP_ASSERT_SVH

// same-cycle implication
`define LPFE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lpfe_pkg.sv =====
package lpfe_pkg;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_PULL    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_DROP  = 3'd2,
        ST_DONE  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // control carried from the accept stage to the store read stage
    typedef struct packed {
        status_t status;
        logic    pull_ok;
        logic    clear;
    } s1_ctl_t;

    localparam int          LEN_W           = 13;
    localparam logic [2:0]  HDR_BYTES       = 3'd4;
    localparam logic [12:0] MAX_PAYLOAD_RST = 13'd4096;
    localparam logic [1:0]  ADDR_MAX_PAYLOAD = 2'd0;

endpackage

// ===== sv/lpfe_ram.sv =====
module lpfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/length_prefixed_frame_echo_top.sv =====
// Length-prefixed frame echo for one connection. Each input beat is a receive, a pull or a
// connection clear, and each gives exactly one result beat. Received bytes (4-byte big-endian
// length, then payload) are written into a BUF_DEPTH-byte ring held in a single-port-write,
// single-port-read RAM; a frame is released to pulls only once its last byte has arrived.
// The block takes one beat every cycle unless a stalled output holds the read stage; the result
// of a beat passes through the read stage into the output register: the RAM's registered read at
// the accept edge supplies a pulled byte, and the output register loads it. Receive and pull
// bookkeeping runs at accept time, the transmit frame tracking runs in the read stage, so
// back-to-back pulls need no stall. A two-entry path (read stage plus output register) keeps
// input accepted while a finished result waits. Store contents are undefined after reset and
// need no clearing pass; pulls only ever reach bytes already written.
module length_prefixed_frame_echo_top
    import lpfe_pkg::*;
#(
    parameter int BUF_DEPTH = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        frame_last
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int PW = $clog2(2 * BUF_DEPTH);

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(2 * BUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_index(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = (p >= PW'(BUF_DEPTH)) ? p - PW'(BUF_DEPTH) : p;
        return d[AW-1:0];
    endfunction

    // configuration
    logic [LEN_W-1:0] max_payload_reg;
    logic             cfg_wr;

    // accept-stage state
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]    cm_ptr_reg, cm_ptr_next;
    logic [31:0]      rx_len_reg, rx_len_next;
    logic [2:0]       rx_hdr_reg, rx_hdr_next;
    logic [LEN_W-1:0] rx_left_reg, rx_left_next;
    logic             dropped_reg, dropped_next;

    // read-stage state
    logic [2:0]       tx_hdr_reg, tx_hdr_next;
    logic [LEN_W-1:0] tx_left_reg, tx_left_next;
    logic             s1_valid_reg;
    s1_ctl_t          s1_ctl_reg;
    s1_ctl_t          s0_ctl;

    // output register
    logic             out_valid_reg;
    status_t          status_reg;
    logic [7:0]       tx_byte_reg;
    logic             tx_valid_reg;
    logic             frame_last_reg;

    logic             accept;
    logic             out_load;
    logic [PW-1:0]    fill;
    logic             full;
    logic [31:0]      rx_len_new;
    logic [2:0]       rx_hdr_new;
    logic [LEN_W-1:0] rx_left_dec;
    logic             tx_last;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    // ------------------------------------------------------------ config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_PAYLOAD);
    assign prdata = (paddr == ADDR_MAX_PAYLOAD) ? 32'(max_payload_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_wr)
        begin
            max_payload_reg <= pwdata[LEN_W-1:0];
        end
    end

    // ------------------------------------------------------------ handshake
    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------ accept stage
    assign fill = (wr_ptr_reg >= rd_ptr_reg)
        ? wr_ptr_reg - rd_ptr_reg
        : PW'({1'b0, wr_ptr_reg} + (PW+1)'(2 * BUF_DEPTH) - {1'b0, rd_ptr_reg});
    assign full        = (fill >= PW'(BUF_DEPTH));
    assign rx_len_new  = {rx_len_reg[23:0], rx_byte};
    assign rx_hdr_new  = rx_hdr_reg + 3'd1;
    assign rx_left_dec = rx_left_reg - 1'b1;

    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        cm_ptr_next    = cm_ptr_reg;
        rx_len_next    = rx_len_reg;
        rx_hdr_next    = rx_hdr_reg;
        rx_left_next   = rx_left_reg;
        dropped_next   = dropped_reg;
        s0_ctl.status  = ST_OK;
        s0_ctl.pull_ok = 1'b0;
        s0_ctl.clear   = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = ptr_index(wr_ptr_reg);
        ram_raddr      = ptr_index(rd_ptr_reg);
        if (accept)
        begin
            case (op_t'(operation))
                OP_RECEIVE:
                begin
                    if (dropped_reg)
                    begin
                        s0_ctl.status = ST_DROP;
                    end
                    else if (full)
                    begin
                        s0_ctl.status = ST_FULL;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = ptr_next(wr_ptr_reg);
                        if (rx_hdr_reg < HDR_BYTES)
                        begin
                            rx_len_next = rx_len_new;
                            rx_hdr_next = rx_hdr_new;
                            if (rx_hdr_new == HDR_BYTES)
                            begin
                                if (rx_len_new > 32'(max_payload_reg))
                                begin
                                    // violation: discard uncommitted bytes
                                    wr_ptr_next   = cm_ptr_reg;
                                    dropped_next  = 1'b1;
                                    s0_ctl.status = ST_DROP;
                                end
                                else if (rx_len_new == 32'd0)
                                begin
                                    cm_ptr_next   = ptr_next(wr_ptr_reg);
                                    rx_hdr_next   = 3'd0;
                                    s0_ctl.status = ST_DONE;
                                end
                                else
                                begin
                                    rx_left_next = rx_len_new[LEN_W-1:0];
                                    rx_len_next  = 32'd0;
                                end
                            end
                        end
                        else
                        begin
                            rx_left_next = rx_left_dec;
                            if (rx_left_dec == '0)
                            begin
                                cm_ptr_next   = ptr_next(wr_ptr_reg);
                                rx_hdr_next   = 3'd0;
                                rx_len_next   = 32'd0;
                                s0_ctl.status = ST_DONE;
                            end
                        end
                    end
                end
                OP_PULL:
                begin
                    if (dropped_reg)
                    begin
                        s0_ctl.status = ST_DROP;
                    end
                    else if (rd_ptr_reg == cm_ptr_reg)
                    begin
                        s0_ctl.status = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re         = 1'b1;
                        rd_ptr_next    = ptr_next(rd_ptr_reg);
                        s0_ctl.pull_ok = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    wr_ptr_next  = '0;
                    rd_ptr_next  = '0;
                    cm_ptr_next  = '0;
                    rx_len_next  = 32'd0;
                    rx_hdr_next  = 3'd0;
                    rx_left_next = '0;
                    dropped_next = 1'b0;
                    s0_ctl.clear = 1'b1;
                end
                default:
                begin
                    s0_ctl.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cm_ptr_reg   <= '0;
            rx_len_reg   <= 32'd0;
            rx_hdr_reg   <= 3'd0;
            rx_left_reg  <= '0;
            dropped_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            cm_ptr_reg  <= cm_ptr_next;
            rx_len_reg  <= rx_len_next;
            rx_hdr_reg  <= rx_hdr_next;
            rx_left_reg <= rx_left_next;
            dropped_reg <= dropped_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_ctl_reg   <= s0_ctl;
            end
            else if (out_load)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    lpfe_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (rx_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------ read stage
    // the pulled byte re-parses the echoed header to find each frame's end
    always_comb
    begin
        tx_hdr_next  = tx_hdr_reg;
        tx_left_next = tx_left_reg;
        tx_last      = 1'b0;
        if (s1_ctl_reg.clear)
        begin
            tx_hdr_next  = 3'd0;
            tx_left_next = '0;
        end
        else if (s1_ctl_reg.pull_ok)
        begin
            if (tx_hdr_reg < HDR_BYTES)
            begin
                tx_left_next = {tx_left_reg[LEN_W-9:0], ram_rdata};
                tx_hdr_next  = tx_hdr_reg + 3'd1;
                if ((tx_hdr_next == HDR_BYTES) && (tx_left_next == '0))
                begin
                    tx_last     = 1'b1;
                    tx_hdr_next = 3'd0;
                end
            end
            else
            begin
                tx_left_next = tx_left_reg - 1'b1;
                if (tx_left_next == '0)
                begin
                    tx_last     = 1'b1;
                    tx_hdr_next = 3'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_hdr_reg    <= 3'd0;
            tx_left_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                tx_hdr_reg    <= tx_hdr_next;
                tx_left_reg   <= tx_left_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg     <= s1_ctl_reg.status;
            tx_byte_reg    <= s1_ctl_reg.pull_ok ? ram_rdata : 8'd0;
            tx_valid_reg   <= s1_ctl_reg.pull_ok;
            frame_last_reg <= tx_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign tx_byte    = tx_byte_reg;
    assign tx_valid   = tx_valid_reg;
    assign frame_last = frame_last_reg;

endmodule

// ===== sv/lpfe_checker.sv =====
`include "length_prefixed_frame_echo_top_assert.svh"

module lpfe_checker
    import lpfe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [7:0] tx_byte,
    input logic       tx_valid,
    input logic       frame_last
);

    // a delivered byte only ever comes with ok status
    `LPFE_ASSERT_SAME(a_tx_ok, clk, rst_n, out_valid && tx_valid, status == ST_OK, "tx byte without ok status")

    // beats without a byte carry zero payload and no end mark
    `LPFE_ASSERT_SAME(a_no_tx_zero, clk, rst_n, out_valid && !tx_valid, (tx_byte == 8'd0) && !frame_last, "stray tx payload")

    `LPFE_ASSERT_SAME(a_last_has_byte, clk, rst_n, out_valid && frame_last, tx_valid, "frame end without byte")

    `LPFE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(tx_byte) && $stable(frame_last), "stalled result changed")

endmodule

bind length_prefixed_frame_echo_top lpfe_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .tx_byte    (tx_byte),
    .tx_valid   (tx_valid),
    .frame_last (frame_last)
);

// ===== dv/length_prefixed_frame_echo_top_test.sv =====
module length_prefixed_frame_echo_top_test;
    import lpfe_pkg::*;

    localparam int RING_DEPTH   = 8192;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 144;
    localparam int SHOWN_ERRORS = 20;

    typedef enum {PACE_NONE, PACE_LIGHT, PACE_HEAVY} pace_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data;
        logic       valid;
        logic       last;
    } echo_beat_t;

    // mirror of one connection: ring, pointers, header trackers and the beats still owed
    class echo_tracker;
        logic [7:0]  ring [RING_DEPTH];
        logic [13:0] wr_ptr;
        logic [13:0] rd_ptr;
        logic [13:0] commit_ptr;
        logic [31:0] rx_len;
        logic [2:0]  rx_hdr;
        logic [12:0] rx_left;
        logic        dropped;
        logic [2:0]  tx_hdr;
        logic [12:0] tx_left;
        logic [12:0] max_len;
        echo_beat_t  expected_beats[$];
        int          error_count;

        function new();
            max_len     = MAX_PAYLOAD_RST;
            error_count = 0;
            wipe();
        endfunction

        function void wipe();
            wr_ptr     = '0;
            rd_ptr     = '0;
            commit_ptr = '0;
            rx_len     = '0;
            rx_hdr     = '0;
            rx_left    = '0;
            dropped    = 1'b0;
            tx_hdr     = '0;
            tx_left    = '0;
        endfunction

        task report(string what);
            error_count++;
            if (error_count <= SHOWN_ERRORS)
                $display("mismatch: %s", what);
        endtask

        function status_t take_byte(logic [7:0] b);
            logic [13:0] fill;
            fill = wr_ptr - rd_ptr;
            if (dropped)
                return ST_DROP;
            if (fill >= 14'(RING_DEPTH))
                return ST_FULL;
            ring[wr_ptr[12:0]] = b;
            wr_ptr++;
            if (rx_hdr < HDR_BYTES) begin
                rx_len = {rx_len[23:0], b};
                rx_hdr++;
                if (rx_hdr < HDR_BYTES)
                    return ST_OK;
                if (rx_len > 32'(max_len)) begin
                    // uncommitted bytes are thrown away
                    wr_ptr  = commit_ptr;
                    dropped = 1'b1;
                    return ST_DROP;
                end
                if (rx_len == '0) begin
                    commit_ptr = wr_ptr;
                    rx_hdr     = '0;
                    return ST_DONE;
                end
                rx_left = rx_len[12:0];
                rx_len  = '0;
                return ST_OK;
            end
            rx_left--;
            if (rx_left == '0) begin
                commit_ptr = wr_ptr;
                rx_hdr     = '0;
                rx_len     = '0;
                return ST_DONE;
            end
            return ST_OK;
        endfunction

        function echo_beat_t fetch_byte();
            echo_beat_t r;
            logic [7:0] b;
            r = '{ST_OK, 8'h00, 1'b0, 1'b0};
            if (dropped) begin
                r.status = ST_DROP;
                return r;
            end
            if (rd_ptr == commit_ptr) begin
                r.status = ST_EMPTY;
                return r;
            end
            b = ring[rd_ptr[12:0]];
            rd_ptr++;
            if (tx_hdr < HDR_BYTES) begin
                tx_left = {tx_left[4:0], b};
                tx_hdr++;
                if (tx_hdr == HDR_BYTES && tx_left == '0) begin
                    r.last = 1'b1;
                    tx_hdr = '0;
                end
            end else begin
                tx_left--;
                if (tx_left == '0) begin
                    r.last = 1'b1;
                    tx_hdr = '0;
                end
            end
            r.data  = b;
            r.valid = 1'b1;
            return r;
        endfunction

        function void note_accepted(op_t op, logic [7:0] b);
            echo_beat_t r;
            r = '{ST_OK, 8'h00, 1'b0, 1'b0};
            case (op)
                OP_RECEIVE: r.status = take_byte(b);
                OP_PULL:    r = fetch_byte();
                OP_CLEAR:   wipe();
                default:    ;
            endcase
            expected_beats.push_back(r);
        endfunction

        task check_beat(logic [2:0] st, logic [7:0] data, logic valid, logic last);
            echo_beat_t want;
            if (expected_beats.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            want = expected_beats.pop_front();
            if (st !== 3'(want.status))
                report($sformatf("status %0d, expected %0d", st, want.status));
            if (data !== want.data)
                report($sformatf("tx_byte %02h, expected %02h", data, want.data));
            if (valid !== want.valid)
                report($sformatf("tx_valid %b, expected %b", valid, want.valid));
            if (last !== want.last)
                report($sformatf("frame_last %b, expected %b", last, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        frame_last;

    echo_tracker tracker;
    pace_t       pace;
    int          sent_items;
    int          results_seen;
    int          cycle_count;

    length_prefixed_frame_echo_top #(
        .BUF_DEPTH(RING_DEPTH)
    ) u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pause_cycles();
        case (pace)
            PACE_NONE:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            default:    return $urandom_range(0, 19);
        endcase
    endfunction

    task automatic send_beat(op_t op, logic [7:0] b);
        int gap;
        gap = pause_cycles();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        tracker.note_accepted(op, b);
        if (op != OP_NONE)
            sent_items++;
    endtask

    task automatic pull_beat();
        send_beat(OP_PULL, 8'($urandom));
    endtask

    // 4-byte big-endian length
    task automatic send_header(logic [31:0] len);
        for (int i = 3; i >= 0; i--)
            send_beat(OP_RECEIVE, len[8*i +: 8]);
    endtask

    task automatic send_frame(logic [31:0] len, int pull_pct);
        send_header(len);
        repeat (len)
        begin
            if ($urandom_range(0, 99) < pull_pct)
                pull_beat();
            send_beat(OP_RECEIVE, 8'($urandom));
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_beats.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_write(logic [12:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_PAYLOAD;
        pwdata  <= {19'($urandom), v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        tracker.max_len = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_check(logic [12:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MAX_PAYLOAD;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata[12:0] !== v)
            tracker.report($sformatf("max_payload reads %0d, expected %0d", prdata[12:0], v));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_max(logic [12:0] v);
        wait_idle();
        apb_write(v);
        apb_check(v);
    endtask

    function automatic int frame_length();
        int cap;
        int r;
        cap = (tracker.max_len < 24) ? int'(tracker.max_len) : 24;
        r   = $urandom_range(0, 9);
        if (r == 0 && tracker.max_len <= 48)
            return int'(tracker.max_len);
        if (r == 1)
            return 0;
        return $urandom_range(0, cap);
    endfunction

    // mostly complete frames with pulls mixed in, some violations and torn frames
    task automatic random_traffic(int n);
        int          target;
        int          kind;
        logic [31:0] len;
        target = sent_items + n;
        while (sent_items < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
                send_frame(frame_length(), 25);
            else if (kind < 75)
                repeat ($urandom_range(1, 12)) pull_beat();
            else if (kind < 83)
            begin
                if ($urandom_range(0, 1) == 0)
                    len = 32'(tracker.max_len) + 1;
                else
                    len = 32'($urandom) | 32'h0000_2000;
                send_header(len);
                repeat ($urandom_range(1, 3))
                    send_beat(op_t'($urandom_range(0, 1)), 8'($urandom));
                send_beat(OP_CLEAR, 8'($urandom));
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 6)) send_beat(OP_RECEIVE, 8'($urandom));
                send_beat(OP_CLEAR, 8'($urandom));
            end
            else if (kind < 95)
                send_beat(OP_NONE, 8'($urandom));
            else
                send_beat(OP_CLEAR, 8'($urandom));
        end
    endtask

    initial
    begin
        logic [12:0] limits [6];
        pace_t       paces  [6];
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        operation  = OP_RECEIVE;
        rx_byte    = '0;
        out_ready  = 1'b0;
        sent_items = 0;
        pace       = PACE_LIGHT;
        tracker    = new();
        limits = '{13'd12, 13'd0, 13'd8188, 13'h1FFF, 13'($urandom_range(1, 8191)), 13'd1};
        paces  = '{PACE_HEAVY, PACE_LIGHT, PACE_NONE, PACE_HEAVY, PACE_LIGHT, PACE_HEAVY};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        apb_check(MAX_PAYLOAD_RST);

        pull_beat();
        send_beat(OP_NONE, 8'hFF);
        send_header(32'h0);
        repeat (4) pull_beat();
        send_header(32'h1);
        send_beat(OP_RECEIVE, 8'hFF);
        repeat (5) pull_beat();
        send_header(32'hFFFF_FFFF);
        send_beat(OP_RECEIVE, 8'h00);
        pull_beat();
        send_beat(OP_CLEAR, 8'h00);

        for (int p = 0; p < 6; p++)
        begin
            set_max(limits[p]);
            pace = paces[p];
            random_traffic(PHASE_ITEMS);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (tracker.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        int stall;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            // one long hold while the sender keeps offering, so the input backs up
            stall = (results_seen == HOLD_AT) ? HOLD_CYCLES : pause_cycles();
            repeat (stall)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            tracker.check_beat(status, tx_byte, tx_valid, frame_last);
            results_seen++;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
